// ----- rtl/gregorian_date_adder_core_macros.svh -----
// Assertion macros for the Gregorian date adder core.
// Used by the top level only; no other dependencies.
`ifndef GREGORIAN_DATE_ADDER_CORE_MACROS_SVH
`define GREGORIAN_DATE_ADDER_CORE_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define GDA_ASSERT_INV(label, clk_s, rstn_s, cond, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (cond)) else $error(msg);

// Same-cycle implication.
`define GDA_ASSERT_IMPL(label, clk_s, rstn_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define GDA_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/gda_pkg.sv -----
// Shared types, codes, constants and calendar functions of the date adder.
// No dependencies; imported by gda_step and gregorian_date_adder_core.
`timescale 1ns / 1ps

package gda_pkg;

  localparam int DAY_W  = 5;
  localparam int MON_W  = 4;
  localparam int YEAR_W = 14;

  localparam logic [YEAR_W-1:0] MAX_YEAR = 14'd9999;
  localparam int COUNT_BITS = 16;
  // Count bits actually taken from the 16-bit day_count field.
  localparam int CNT_W = (COUNT_BITS < 16) ? COUNT_BITS : 16;
  // Subtractor width: holds the count or a year length, plus a borrow bit.
  localparam int SUB_W = ((CNT_W > 9) ? CNT_W : 9) + 1;

  localparam logic [1:0] FN_LOAD = 2'd0;
  localparam logic [1:0] FN_ADD  = 2'd1;
  localparam logic [1:0] FN_SUB  = 2'd2;
  localparam logic [1:0] FN_CMP  = 2'd3;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_INVALID = 2'd1;
  localparam logic [1:0] STAT_SAT     = 2'd2;

  localparam logic [1:0] ORD_EQUAL   = 2'd0;
  localparam logic [1:0] ORD_EARLIER = 2'd1;
  localparam logic [1:0] ORD_LATER   = 2'd2;

  localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef struct packed {
    logic [YEAR_W-1:0] year;
    logic [MON_W-1:0]  month;
    logic [DAY_W-1:0]  day;
  } date_t;

  typedef struct packed {
    logic done;       // count used up or limit reached
    logic sat;        // stopped at a calendar limit with days left
    logic year_miss;  // whole-year jump did not fit the remaining count
  } step_res_t;

  // Leap rule. The century test divides y/4 by 25 through a reciprocal
  // multiply, which is exact for every 12-bit quotient.
  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    logic [11:0] x;
    logic [23:0] prod;
    logic [7:0]  q;
    logic [11:0] q_ext;
    logic [11:0] q25;
    logic        century;
    x       = y[YEAR_W-1:2];
    prod    = {12'd0, x} * 24'd1311;
    q       = prod[22:15];
    q_ext   = {4'd0, q};
    q25     = (q_ext << 4) + (q_ext << 3) + q_ext;
    century = (q25 == x);
    return (y[1:0] == 2'd0) && (!century || (q[1:0] == 2'd0));
  endfunction

  function automatic logic [DAY_W-1:0] days_in_month(input logic [MON_W-1:0] m,
                                                     input logic leap);
    logic [DAY_W-1:0] len;
    if ((m < 4'd1) || (m > 4'd12)) begin
      len = 5'd31;
    end else if ((m == 4'd2) && leap) begin
      len = 5'd29;
    end else begin
      len = MONTH_LEN[4'(m - 4'd1)];
    end
    return len;
  endfunction

  function automatic logic date_valid(input logic [DAY_W-1:0] d,
                                      input logic [MON_W-1:0] m,
                                      input logic [YEAR_W-1:0] y);
    logic ok;
    ok = (y != '0) && (y <= MAX_YEAR) && (m >= 4'd1) && (m <= 4'd12) && (d != '0);
    return ok && (d <= days_in_month(m, is_leap(y)));
  endfunction

endpackage

// ----- rtl/gda_step.sv -----
// One step of the day-count walk: a whole year, the rest of a month, or the final days.
// Depends on gda_pkg; instantiated by gregorian_date_adder_core.
`timescale 1ns / 1ps

module gda_step (
  input  gda_pkg::date_t             cur,
  input  logic [gda_pkg::CNT_W-1:0]  cnt,
  input  logic                       down,
  input  logic                       no_year,
  output gda_pkg::date_t             nxt,
  output logic [gda_pkg::CNT_W-1:0]  cnt_nxt,
  output gda_pkg::step_res_t         res
);
  import gda_pkg::*;

  logic             leap_y;
  logic [DAY_W-1:0] dim;
  logic [8:0]       ylen;
  logic             use_year;
  logic [8:0]       k;
  logic [SUB_W-1:0] diff;
  logic             borrow;
  logic [DAY_W-1:0] n_lo;

  assign leap_y = is_leap(cur.year);
  assign dim    = days_in_month(cur.month, leap_y);
  assign ylen   = leap_y ? 9'd366 : 9'd365;
  assign n_lo   = cnt[DAY_W-1:0];

  assign use_year = !no_year &&
                    (down ? ((cur.month == 4'd12) && (cur.day == 5'd31) &&
                             (cur.year >= 14'd2))
                          : ((cur.month == 4'd1) && (cur.day == 5'd1) &&
                             (cur.year < MAX_YEAR)));

  // The one shared subtractor: remaining count minus the days this step would use.
  always_comb begin
    if (use_year) begin
      k = ylen;
    end else if (down) begin
      k = {4'd0, cur.day};
    end else begin
      k = 9'({4'd0, dim} - {4'd0, cur.day} + 9'd1);
    end
  end

  assign diff   = SUB_W'(cnt) - SUB_W'(k);
  assign borrow = diff[SUB_W-1];

  always_comb begin
    nxt     = cur;
    cnt_nxt = cnt;
    res     = '0;
    priority if (cnt == '0) begin
      res.done = 1'b1;
    end else if (!down && (cur.year > MAX_YEAR)) begin
      nxt.day   = 5'd31;
      nxt.month = 4'd12;
      nxt.year  = MAX_YEAR;
      res.sat   = 1'b1;
      res.done  = 1'b1;
    end else if (use_year) begin
      if (borrow) begin
        res.year_miss = 1'b1;
      end else begin
        nxt.year = down ? (cur.year - 14'd1) : (cur.year + 14'd1);
        cnt_nxt  = diff[CNT_W-1:0];
      end
    end else if (borrow) begin
      nxt.day  = down ? (cur.day - n_lo) : (cur.day + n_lo);
      res.done = 1'b1;
    end else if (!down && (cur.year == MAX_YEAR) && (cur.month == 4'd12)) begin
      nxt.day  = 5'd31;
      res.sat  = 1'b1;
      res.done = 1'b1;
    end else if (down && (cur.month == 4'd1) && (cur.year <= 14'd1)) begin
      nxt.day  = 5'd1;
      nxt.year = 14'd1;
      res.sat  = 1'b1;
      res.done = 1'b1;
    end else begin
      cnt_nxt = diff[CNT_W-1:0];
      if (down) begin
        if (cur.month == 4'd1) begin
          nxt.month = 4'd12;
          nxt.year  = cur.year - 14'd1;
          nxt.day   = 5'd31;
        end else begin
          nxt.month = cur.month - 4'd1;
          nxt.day   = days_in_month(cur.month - 4'd1, leap_y);
        end
      end else begin
        nxt.day = 5'd1;
        if (cur.month == 4'd12) begin
          nxt.month = 4'd1;
          nxt.year  = cur.year + 14'd1;
        end else begin
          nxt.month = cur.month + 4'd1;
        end
      end
    end
  end

endmodule

// ----- rtl/gregorian_date_adder_core.sv -----
// Top level of the Gregorian date adder: stream ports, sequencer, stored date, result register.
// Depends on gda_pkg, gda_step and gregorian_date_adder_core_macros.svh.
`timescale 1ns / 1ps
`include "gregorian_date_adder_core_macros.svh"

// Channel   Direction  Handshake            Payload
// in_       slave      in_tvalid/in_tready  tdata: date and day count, tuser: operation
// out_      master     out_tvalid/out_tready tdata: stored date, tuser: status and order
//
// Load and compare pass from the idle state through the done state into the result register.
// Add and subtract also pass through the run state, which walks the count in steps of the
// shared step unit: one step per whole year crossed from Jan 1 (or back from Dec 31), one per
// month boundary crossed, plus one when a year jump first fails to fit, and a final step.
// Synchronous active-low reset sets the date to 01.01.2000 and empties the result slot.
// A waiting result does not block the next input transaction; a finished operation
// waits in its done state until the result register is free.

module gregorian_date_adder_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // day_in[4:0], month_in[8:5], year_in[22:9],
                                  // day_count[38:23], zero pad[39]
  input  logic [1:0]  in_tuser,   // func[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // day_out[4:0], month_out[8:5], year_out[22:9]
  output logic [3:0]  out_tuser   // status[1:0], order[3:2]
);
  import gda_pkg::*;

  // Idle takes the next transaction, run walks the count, done hands off the result.
  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_t;

  state_t           state_r;
  date_t            cur_r;
  logic [CNT_W-1:0] cnt_r;
  logic             down_r;
  logic             no_year_r;
  logic [1:0]       stat_r;
  logic [1:0]       ord_r;
  logic             out_tvalid_r;
  date_t            out_date_r;
  logic [1:0]       out_stat_r;
  logic [1:0]       out_ord_r;

  // Input fields.
  logic [1:0]        func;
  logic [DAY_W-1:0]  day_in;
  logic [MON_W-1:0]  month_in;
  logic [YEAR_W-1:0] year_in;
  logic [CNT_W-1:0]  count_in;

  assign func     = in_tuser;
  assign day_in   = in_tdata[4:0];
  assign month_in = in_tdata[8:5];
  assign year_in  = in_tdata[22:9];
  assign count_in = in_tdata[23 +: CNT_W];

  logic                    in_fire;
  logic                    load_ok;
  logic [22:0]             cmp_a;
  logic [22:0]             cmp_b;
  logic [1:0]              cmp_ord;
  logic                    out_free;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign load_ok   = date_valid(day_in, month_in, year_in);

  // Compare orders the raw input fields by year, then month, then day.
  assign cmp_a   = {year_in, month_in, day_in};
  assign cmp_b   = {cur_r.year, cur_r.month, cur_r.day};
  assign cmp_ord = (cmp_a == cmp_b) ? ORD_EQUAL : ((cmp_a < cmp_b) ? ORD_EARLIER : ORD_LATER);

  assign out_free = !out_tvalid_r || out_tready;

  // Shared step unit.
  date_t            step_nxt;
  logic [CNT_W-1:0] step_cnt;
  step_res_t        step_res;

  gda_step u_step (
    .cur     (cur_r),
    .cnt     (cnt_r),
    .down    (down_r),
    .no_year (no_year_r),
    .nxt     (step_nxt),
    .cnt_nxt (step_cnt),
    .res     (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cur_r.day    <= 5'd1;
      cur_r.month  <= 4'd1;
      cur_r.year   <= 14'd2000;
      out_tvalid_r <= 1'b0;
      no_year_r    <= 1'b0;
      down_r       <= 1'b0;
    end else begin
      // In the done state the result slot is refilled whenever it drains.
      if (out_tvalid_r && out_tready && (state_r != ST_DONE)) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            unique case (func)
              FN_LOAD: begin
                if (load_ok) begin
                  cur_r.day   <= day_in;
                  cur_r.month <= month_in;
                  cur_r.year  <= year_in;
                end
                stat_r  <= load_ok ? STAT_OK : STAT_INVALID;
                ord_r   <= ORD_EQUAL;
                state_r <= ST_DONE;
              end
              FN_ADD, FN_SUB: begin
                cnt_r     <= count_in;
                down_r    <= (func == FN_SUB);
                no_year_r <= 1'b0;
                stat_r    <= STAT_OK;
                ord_r     <= ORD_EQUAL;
                state_r   <= ST_RUN;
              end
              FN_CMP: begin
                stat_r  <= STAT_OK;
                ord_r   <= cmp_ord;
                state_r <= ST_DONE;
              end
              default: begin
                stat_r  <= STAT_OK;
                ord_r   <= ORD_EQUAL;
                state_r <= ST_DONE;
              end
            endcase
          end
        end
        ST_RUN: begin
          cur_r <= step_nxt;
          cnt_r <= step_cnt;
          if (step_res.year_miss) begin
            no_year_r <= 1'b1;
          end
          if (step_res.done) begin
            stat_r  <= step_res.sat ? STAT_SAT : STAT_OK;
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_date_r   <= cur_r;
            out_stat_r   <= stat_r;
            out_ord_r    <= ord_r;
            out_tvalid_r <= 1'b1;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {out_date_r.year, out_date_r.month, out_date_r.day};
  assign out_tuser  = {out_ord_r, out_stat_r};

  // The stored date always holds a real month and a nonzero day.
  `GDA_ASSERT_INV(a_cur_date_sane, clk, rst_n, (cur_r.month >= 4'd1) && (cur_r.month <= 4'd12) && (cur_r.day != 5'd0), "stored date out of range")
  // Only one operation is in flight at a time.
  `GDA_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_tvalid && in_tready, !in_tready, "input taken while busy")
  // A saturated result sits on one of the two calendar limits.
  `GDA_ASSERT_IMPL(a_sat_at_limit, clk, rst_n, out_tvalid_r && (out_stat_r == STAT_SAT), ((out_date_r.day == 5'd31) && (out_date_r.month == 4'd12) && (out_date_r.year == MAX_YEAR)) || ((out_date_r.day == 5'd1) && (out_date_r.month == 4'd1) && (out_date_r.year == 14'd1)), "saturated date is not a limit")

endmodule
